// File: design/keyed_table_with_nearest_search_assert.svh
// Assertion macros for the keyed table block.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef KEYED_TABLE_WITH_NEAREST_SEARCH_ASSERT_SVH
`define KEYED_TABLE_WITH_NEAREST_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KTNS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define KTNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ktns_pkg.sv
// Shared types and constants for the keyed table with nearest search.
// No dependencies.
`timescale 1ns / 1ps

package ktns_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int GROUP_COUNT = 64;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int OP_W  = 3;
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int GRP_W = 6;
   localparam int ST_W  = 2;
   localparam int RIDX_W = 8;

   // opcodes
   localparam logic [OP_W-1:0] OP_UPSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_FIND_IDX   = 3'd1;
   localparam logic [OP_W-1:0] OP_VAL_BY_KEY = 3'd2;
   localparam logic [OP_W-1:0] OP_IDX_BY_VAL = 3'd3;
   localparam logic [OP_W-1:0] OP_NEXT_HI    = 3'd4;
   localparam logic [OP_W-1:0] OP_NEXT_LO    = 3'd5;

   // response status codes
   localparam logic [ST_W-1:0] STAT_FOUND = 2'd0;
   localparam logic [ST_W-1:0] STAT_NEW   = 2'd1;
   localparam logic [ST_W-1:0] STAT_NONE  = 2'd2;
   localparam logic [ST_W-1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [GRP_W-1:0] group;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// File: design/ktns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ktns_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/keyed_table_with_nearest_search.sv
// Keyed table with nearest-key search: top level, sequencer and scan datapath.
// Depends on ktns_pkg, ktns_ram and keyed_table_with_nearest_search_assert.svh.
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// --------  -------------------------------------------  ---------------------------
// request   req_opcode, req_key, req_value, req_group    taken when start && !busy
// response  rsp_status, rsp_index, rsp_found_key,        one cycle, marked by
//           rsp_found_value                              rsp_strobe
//
// Every valid request scans all TABLE_DEPTH entries: the scan reads one entry
// per cycle through the single RAM read port, the DRAIN state drains the
// registered read, and the FINISH state decides and writes back. The
// response strobes in the cycle after that, when busy is already low again.
// Unused opcodes skip the scan and go straight to the FINISH state.
// Reset clears the fill count, not the RAM; entries at or above it read as empty, so
// there is no clearing pass. The receiver cannot stall the response.

module keyed_table_with_nearest_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ktns_pkg::OP_W-1:0]    req_opcode,
   input  logic [ktns_pkg::KEY_W-1:0]   req_key,
   input  logic [ktns_pkg::VAL_W-1:0]   req_value,
   input  logic [ktns_pkg::GRP_W-1:0]   req_group,
   output logic                         rsp_strobe,
   output logic [ktns_pkg::ST_W-1:0]    rsp_status,
   output logic [ktns_pkg::RIDX_W-1:0]  rsp_index,
   output logic [ktns_pkg::KEY_W-1:0]   rsp_found_key,
   output logic [ktns_pkg::VAL_W-1:0]   rsp_found_value
);

   localparam int IDX_W = ktns_pkg::IDX_W;
   localparam int CNT_W = ktns_pkg::CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ktns_pkg::TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ktns_pkg::TABLE_DEPTH);

   // sequencer
   ktns_pkg::state_type state_ff, state_in;

   // latched request
   logic [ktns_pkg::OP_W-1:0]  op_ff,    op_in;
   logic [ktns_pkg::KEY_W-1:0] key_ff,   key_in;
   logic [ktns_pkg::VAL_W-1:0] value_ff, value_in;
   logic [ktns_pkg::GRP_W-1:0] group_ff, group_in;

   // scan address and read pipeline
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // best candidate so far
   logic                    hit_ff,  hit_in;
   logic                    done_ff, done_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   ktns_pkg::entry_type     best_ff, best_in;

   // fill count: entries below it are live
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;

   // response registers
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [ktns_pkg::ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ktns_pkg::RIDX_W-1:0] rsp_index_ff,  rsp_index_in;
   logic [ktns_pkg::KEY_W-1:0]  rsp_key_ff,    rsp_key_in;
   logic [ktns_pkg::VAL_W-1:0]  rsp_value_ff,  rsp_value_in;

   // RAM port
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   ktns_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [$bits(ktns_pkg::entry_type)-1:0] ram_rd_raw;

   logic                accept;
   logic                req_op_valid;
   ktns_pkg::entry_type ent;
   logic                ent_live;
   logic                key_eq, val_eq, grp_eq, key_gt, key_lt, best_gt, best_lt;
   logic                group_bad;
   logic [31:0]         idx_wide;

   assign accept       = start && !busy;
   assign req_op_valid = (req_opcode <= ktns_pkg::OP_NEXT_LO);
   assign busy         = (state_ff != ktns_pkg::ST_IDLE);

   ktns_ram #(
      .WIDTH ($bits(ktns_pkg::entry_type)),
      .DEPTH (ktns_pkg::TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_raw)
   );

   // Entries at or above the fill count are treated as empty: they read as zero.
   assign ent_live = (CNT_W'(rd_idx_ff) < entry_count_ff);
   assign ent      = ent_live ? ktns_pkg::entry_type'(ram_rd_raw) : '0;

   // shared compare unit for the entry under scan
   assign key_eq  = (ent.key == key_ff);
   assign val_eq  = (ent.value == value_ff);
   assign grp_eq  = (ent.group == group_ff);
   assign key_gt  = (ent.key > key_ff);
   assign key_lt  = (ent.key < key_ff);
   assign best_gt = (ent.key > best_ff.key);
   assign best_lt = (ent.key < best_ff.key);

   assign group_bad = (32'(group_ff) >= 32'(ktns_pkg::GROUP_COUNT));
   assign idx_wide  = 32'(best_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ktns_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_op_valid ? ktns_pkg::ST_SCAN : ktns_pkg::ST_FINISH;
            end
         end
         ktns_pkg::ST_SCAN: begin
            if (ptr_ff == LAST_IDX) begin
               state_in = ktns_pkg::ST_DRAIN;
            end
         end
         ktns_pkg::ST_DRAIN:  state_in = ktns_pkg::ST_FINISH;
         ktns_pkg::ST_FINISH: state_in = ktns_pkg::ST_IDLE;
         default:             state_in = ktns_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      group_in       = group_ff;
      ptr_in         = ptr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = ptr_ff;
      hit_in         = hit_ff;
      done_in        = done_ff;
      best_idx_in    = best_idx_ff;
      best_in        = best_ff;
      entry_count_in = entry_count_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_value_in   = rsp_value_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = best_idx_ff;
      ram_wr_data    = best_ff;
      ram_rd_en      = 1'b0;

      if (accept) begin
         op_in    = req_opcode;
         key_in   = req_key;
         value_in = req_value;
         group_in = req_group;
         ptr_in   = '0;
         hit_in   = 1'b0;
         done_in  = 1'b0;
      end

      if (state_ff == ktns_pkg::ST_SCAN) begin
         ram_rd_en = 1'b1;
         rd_vld_in = 1'b1;
         ptr_in    = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      end

      // one entry per cycle, evaluated in the cycle after its read address
      if (rd_vld_ff && !done_ff) begin
         unique case (op_ff)
            ktns_pkg::OP_UPSERT, ktns_pkg::OP_FIND_IDX: begin
               // stops at the first empty entry or the first key match
               if (ent.key == '0) begin
                  done_in = 1'b1;
               end else if (key_eq) begin
                  hit_in      = 1'b1;
                  done_in     = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = ent;
               end
            end
            ktns_pkg::OP_VAL_BY_KEY: begin
               if (key_eq) begin
                  hit_in      = 1'b1;
                  done_in     = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = ent;
               end
            end
            ktns_pkg::OP_IDX_BY_VAL: begin
               // keep the last match: highest index wins
               if (val_eq) begin
                  hit_in      = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = ent;
               end
            end
            ktns_pkg::OP_NEXT_HI: begin
               if (grp_eq && key_gt && (!hit_ff || best_lt)) begin
                  hit_in      = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = ent;
               end
            end
            ktns_pkg::OP_NEXT_LO: begin
               if (grp_eq && key_lt && (!hit_ff || best_gt)) begin
                  hit_in      = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = ent;
               end
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ktns_pkg::ST_FINISH) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = ktns_pkg::STAT_NONE;
         rsp_index_in  = '0;
         rsp_key_in    = '0;
         rsp_value_in  = '0;
         priority if (op_ff == ktns_pkg::OP_UPSERT) begin
            if (hit_ff) begin
               // update the value in place
               ram_wr_en         = 1'b1;
               ram_wr_addr       = best_idx_ff;
               ram_wr_data       = best_ff;
               ram_wr_data.value = value_ff;
               rsp_status_in     = ktns_pkg::STAT_FOUND;
               rsp_index_in      = idx_wide[ktns_pkg::RIDX_W-1:0];
               rsp_key_in        = best_ff.key;
               rsp_value_in      = value_ff;
            end else if (entry_count_ff == FULL_CNT) begin
               rsp_status_in = ktns_pkg::STAT_FULL;
            end else begin
               // append at the fill count
               ram_wr_en         = 1'b1;
               ram_wr_addr       = entry_count_ff[IDX_W-1:0];
               ram_wr_data.key   = key_ff;
               ram_wr_data.value = value_ff;
               ram_wr_data.group = group_ff;
               entry_count_in    = entry_count_ff + 1'b1;
               rsp_status_in     = ktns_pkg::STAT_NEW;
               rsp_index_in      = ktns_pkg::RIDX_W'(entry_count_ff);
               rsp_key_in        = key_ff;
               rsp_value_in      = value_ff;
            end
         end else if (op_ff > ktns_pkg::OP_NEXT_LO) begin
            rsp_status_in = ktns_pkg::STAT_NONE;
         end else if (hit_ff && !(group_bad && (op_ff == ktns_pkg::OP_NEXT_HI ||
                                                op_ff == ktns_pkg::OP_NEXT_LO))) begin
            rsp_status_in = ktns_pkg::STAT_FOUND;
            rsp_index_in  = idx_wide[ktns_pkg::RIDX_W-1:0];
            rsp_key_in    = best_ff.key;
            rsp_value_in  = best_ff.value;
         end else begin
            rsp_status_in = ktns_pkg::STAT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ktns_pkg::ST_IDLE;
         rd_vld_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         done_ff        <= 1'b0;
         ptr_ff         <= '0;
         entry_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_vld_ff      <= rd_vld_in;
         hit_ff         <= hit_in;
         done_ff        <= done_in;
         ptr_ff         <= ptr_in;
         entry_count_ff <= entry_count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      group_ff      <= group_in;
      rd_idx_ff     <= rd_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_found_key   = rsp_key_ff;
   assign rsp_found_value = rsp_value_ff;

`include "keyed_table_with_nearest_search_assert.svh"

   `KTNS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy,
                     "request accepted but not busy")
   `KTNS_ASSERT_NEXT(a_finish_strobe, clock, reset, state_ff == ktns_pkg::ST_FINISH,
                     rsp_strobe && !busy, "no response after finish")
   `KTNS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, entry_count_ff <= FULL_CNT,
                     "fill count past table depth")
   `KTNS_ASSERT_IMPL(a_new_counts, clock, reset,
                     rsp_strobe && rsp_status == ktns_pkg::STAT_NEW,
                     entry_count_ff == $past(entry_count_ff) + 1'b1,
                     "insert without count step")
   `KTNS_ASSERT_IMPL(a_miss_zero, clock, reset,
                     rsp_strobe && (rsp_status == ktns_pkg::STAT_NONE ||
                                    rsp_status == ktns_pkg::STAT_FULL),
                     rsp_index == '0 && rsp_found_key == '0 && rsp_found_value == '0,
                     "miss with nonzero fields")

endmodule
